/* rtl/affine_cipher_printable_ascii_top_macros.svh */
// assertion macros for the affine cipher block
`ifndef AFFINE_CIPHER_PRINTABLE_ASCII_TOP_MACROS_SVH
`define AFFINE_CIPHER_PRINTABLE_ASCII_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define ACPA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication checked on every clock edge, reset included
`define ACPA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/acpa_pkg.sv */
// shared types and constants for the affine cipher block
`timescale 1ns / 1ps
`default_nettype none
package acpa_pkg;

    localparam int ALPHABET_SIZE = 95;
    localparam int FIRST_CODE    = 32;

    localparam int CODE_W  = 8;
    localparam int KEY_W   = 7;
    localparam int IDX_W   = $clog2(ALPHABET_SIZE);
    localparam int PROD_W  = 2 * IDX_W + 1;
    localparam int RECIP_SHIFT = PROD_W;
    localparam int RECIP   = (1 << RECIP_SHIFT) / ALPHABET_SIZE;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_KEY_MULT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_SHIFT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DIRECTION = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INV_INIT,
        ST_INV_SEARCH,
        ST_MUL,
        ST_QUOT,
        ST_REDUCE
    } state_t;

    typedef struct packed {
        logic load_char;
        logic inv_init;
        logic inv_step;
        logic mul;
        logic quot;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic inv_ready;
        logic inv_done;
        logic in_range;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

/* rtl/acpa_ctrl.sv */
// controller state machine for the affine cipher block
`timescale 1ns / 1ps
`default_nettype none
module acpa_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  acpa_pkg::status_t     status,
    output acpa_pkg::cmd_t        cmd
);

    acpa_pkg::state_t state_reg;
    acpa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= acpa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            acpa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_char = 1'b1;
                    state_next = status.inv_ready ? acpa_pkg::ST_MUL : acpa_pkg::ST_INV_INIT;
                end
            end
            acpa_pkg::ST_INV_INIT: begin
                cmd.inv_init = 1'b1;
                state_next   = acpa_pkg::ST_INV_SEARCH;
            end
            acpa_pkg::ST_INV_SEARCH: begin
                cmd.inv_step = 1'b1;
                if (status.inv_done) begin
                    state_next = acpa_pkg::ST_MUL;
                end
            end
            acpa_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = status.in_range ? acpa_pkg::ST_QUOT : acpa_pkg::ST_IDLE;
            end
            acpa_pkg::ST_QUOT: begin
                cmd.quot   = 1'b1;
                state_next = acpa_pkg::ST_REDUCE;
            end
            acpa_pkg::ST_REDUCE: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = acpa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = acpa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/acpa_datapath.sv */
// key registers, inverse search, multiply and modulo datapath
`timescale 1ns / 1ps
`default_nettype none
module acpa_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [acpa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [acpa_pkg::KEY_W-1:0]        cfg_wdata,
    input  wire logic [acpa_pkg::CODE_W-1:0]       s_tdata,
    output logic [acpa_pkg::CODE_W-1:0]            m_tdata,
    output logic                                   m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  acpa_pkg::cmd_t                         cmd,
    output acpa_pkg::status_t                      status
);

    localparam int IDX_W  = acpa_pkg::IDX_W;
    localparam int PROD_W = acpa_pkg::PROD_W;
    localparam int WIDE_W = 2 * PROD_W;
    localparam int CHK_W  = acpa_pkg::CODE_W + 1;
    localparam logic [IDX_W-1:0] M_IDX   = IDX_W'(acpa_pkg::ALPHABET_SIZE);
    localparam logic [IDX_W-1:0] M_LAST  = IDX_W'(acpa_pkg::ALPHABET_SIZE - 1);
    localparam logic [IDX_W:0]   M_EXT   = (IDX_W+1)'(acpa_pkg::ALPHABET_SIZE);
    localparam logic [PROD_W-1:0] M_PROD = PROD_W'(acpa_pkg::ALPHABET_SIZE);
    localparam logic [PROD_W-1:0] RECIP_C = PROD_W'(acpa_pkg::RECIP);
    localparam logic [CHK_W-1:0] FIRST_CHK = CHK_W'(acpa_pkg::FIRST_CODE);
    localparam logic [CHK_W-1:0] M_CHK     = CHK_W'(acpa_pkg::ALPHABET_SIZE);

    logic [acpa_pkg::KEY_W-1:0]  key_mult_reg;
    logic [acpa_pkg::KEY_W-1:0]  key_shift_reg;
    logic                        direction_reg;
    logic                        inv_ready_reg;
    logic [IDX_W-1:0]            inv_reg;
    logic [IDX_W-1:0]            inv_t_reg;
    logic [IDX_W-1:0]            inv_acc_reg;
    logic [acpa_pkg::CODE_W-1:0] char_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [PROD_W-1:0]           quot_reg;
    logic [acpa_pkg::CODE_W-1:0] out_char_reg;
    logic                        out_err_reg;
    logic                        out_valid_reg;

    logic [IDX_W-1:0]  a_red;
    logic [IDX_W-1:0]  b_red;
    logic [CHK_W-1:0]  char_off;
    logic              in_range;
    logic [IDX_W-1:0]  j_idx;
    logic [IDX_W-1:0]  d_idx;
    logic [IDX_W:0]    acc_sum;
    logic [IDX_W-1:0]  acc_next;
    logic              inv_hit;
    logic [IDX_W-1:0]  mul_x;
    logic [IDX_W-1:0]  mul_y;
    logic [PROD_W-1:0] prod_next;
    logic [WIDE_W-1:0] quot_wide;
    logic [PROD_W-1:0] rem_wide;
    logic [IDX_W-1:0]  r_idx;
    logic [acpa_pkg::CODE_W-1:0] code_next;

    // keys reduced into the alphabet range
    always_comb begin
        a_red = (key_mult_reg >= M_IDX) ? IDX_W'(key_mult_reg - M_IDX) : IDX_W'(key_mult_reg);
        b_red = (key_shift_reg >= M_IDX) ? IDX_W'(key_shift_reg - M_IDX) : IDX_W'(key_shift_reg);
    end

    always_comb begin
        char_off = CHK_W'(char_reg) - FIRST_CHK;
        in_range = (CHK_W'(char_reg) >= FIRST_CHK) && (char_off < M_CHK);
        j_idx    = char_off[IDX_W-1:0];
        d_idx    = (j_idx >= b_red) ? IDX_W'(j_idx - b_red) : IDX_W'(j_idx + M_IDX - b_red);
        acc_sum  = {1'b0, inv_acc_reg} + {1'b0, a_red};
        acc_next = (acc_sum >= M_EXT) ? IDX_W'(acc_sum - M_EXT) : acc_sum[IDX_W-1:0];
        inv_hit  = (inv_acc_reg == IDX_W'(1));
    end

    always_comb begin
        mul_x     = direction_reg ? inv_reg : a_red;
        mul_y     = direction_reg ? d_idx : j_idx;
        prod_next = PROD_W'(mul_x) * PROD_W'(mul_y) + (direction_reg ? '0 : PROD_W'(b_red));
        quot_wide = WIDE_W'(prod_reg) * WIDE_W'(RECIP_C);
        rem_wide  = prod_reg - PROD_W'(quot_reg * M_PROD);
        r_idx     = (rem_wide >= M_PROD) ? IDX_W'(rem_wide - M_PROD) : rem_wide[IDX_W-1:0];
        code_next = acpa_pkg::CODE_W'(acpa_pkg::FIRST_CODE) + acpa_pkg::CODE_W'(r_idx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_mult_reg  <= acpa_pkg::KEY_W'(1);
            key_shift_reg <= '0;
            direction_reg <= 1'b0;
            inv_ready_reg <= 1'b0;
            inv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    acpa_pkg::REG_KEY_MULT: begin
                        key_mult_reg  <= cfg_wdata;
                        inv_ready_reg <= 1'b0;
                    end
                    acpa_pkg::REG_KEY_SHIFT: begin
                        key_shift_reg <= cfg_wdata;
                        inv_ready_reg <= 1'b0;
                    end
                    acpa_pkg::REG_DIRECTION: begin
                        direction_reg <= cfg_wdata[0];
                        inv_ready_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.inv_step && (inv_hit || inv_t_reg == M_LAST)) begin
                inv_reg       <= inv_hit ? inv_t_reg : '0;
                inv_ready_reg <= 1'b1;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_char) begin
            char_reg <= s_tdata;
        end
        if (cmd.inv_init) begin
            inv_t_reg   <= IDX_W'(1);
            inv_acc_reg <= a_red;
        end else if (cmd.inv_step) begin
            inv_t_reg   <= inv_t_reg + IDX_W'(1);
            inv_acc_reg <= acc_next;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.quot) begin
            quot_reg <= quot_wide[acpa_pkg::RECIP_SHIFT +: PROD_W];
        end
        if (cmd.load_out) begin
            out_char_reg <= (inv_reg == '0) ? '0 : code_next;
            out_err_reg  <= (inv_reg == '0);
        end
    end

    assign status.inv_ready = inv_ready_reg;
    assign status.inv_done  = inv_hit || (inv_t_reg == M_LAST);
    assign status.in_range  = in_range;
    assign status.out_busy  = out_valid_reg && !m_tready;

    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_err_reg;
    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

/* rtl/affine_cipher_printable_ascii_top.sv */
// top level of the affine cipher over printable ascii
//
//  port group  dir  tdata (low bit up)   tuser
//  s_          in   in_char[7:0]         none
//  m_          out  out_char[7:0]        key_error
//  cfg_        in   addr 0 key_mult, 1 key_shift, 2 direction
//
//  a character in the alphabet passes the states mul, quot and reduce after
//  accept, and the next one is taken once the result is loaded; one outside
//  the alphabet goes from mul back to idle and gives no beat
//  the first character after reset or a register write first runs the inverse
//  search through inv_init and inv_search, one modular add of a per cycle
//  reset is synchronous; a stalled m_ side holds the result and the next
//  character is taken while the result waits
`timescale 1ns / 1ps
`default_nettype none
`include "affine_cipher_printable_ascii_top_macros.svh"
module affine_cipher_printable_ascii_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [acpa_pkg::CODE_W-1:0]       s_tdata,   // in_char
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [acpa_pkg::CODE_W-1:0]            m_tdata,   // out_char
    output logic                                   m_tuser,   // key_error
    input  wire logic                              cfg_we,
    input  wire logic [acpa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [acpa_pkg::KEY_W-1:0]        cfg_wdata
);

    acpa_pkg::cmd_t    cmd;
    acpa_pkg::status_t status;

    acpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    acpa_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    `ACPA_ASSERT(a_err_zero, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata == '0), "key error beat carries a nonzero char")
    `ACPA_ASSERT(a_ok_printable, aclk, aresetn, (m_tvalid && !m_tuser) |-> (m_tdata >= acpa_pkg::CODE_W'(acpa_pkg::FIRST_CODE)), "result char below alphabet")
    `ACPA_ASSERT(a_no_overwrite, aclk, aresetn, cmd.load_out |-> !status.out_busy, "result loaded over a pending beat")
    `ACPA_ASSERT_ALWAYS(a_one_at_a_time, aclk, (aresetn && s_tvalid && s_tready) |=> !s_tready, "second beat taken while busy")

endmodule
`default_nettype wire
